[sv/ams_pkg.sv]
`default_nettype none
package ams_pkg;

  localparam int GROUND_DEPTH = 32;
  localparam int DATA_WIDTH   = 16;
  localparam int PROG_DEPTH   = 256;

  // widths fixed by the item fields
  localparam int OP_W     = 3;
  localparam int ARG_W    = 8;
  localparam int INBOX_W  = 16;
  localparam int PC_W     = 9;
  localparam int GIDX_W   = (GROUND_DEPTH > 1) ? $clog2(GROUND_DEPTH) : 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [PC_W-1:0]       pc_t;
  typedef logic [GIDX_W-1:0]     gidx_t;

  typedef enum logic [OP_W-1:0] {
    OP_INBOX    = 3'd0,
    OP_OUTBOX   = 3'd1,
    OP_ADD      = 3'd2,
    OP_SUB      = 3'd3,
    OP_COPYTO   = 3'd4,
    OP_COPYFROM = 3'd5,
    OP_JUMP     = 3'd6,
    OP_JUMPZERO = 3'd7
  } op_t;

  // result of executing one instruction
  typedef struct packed {
    data_t hand;
    pc_t   pc;
    logic  gnd_we;
    logic  out_valid;
    data_t out_value;
    logic  halted;
    logic  fault;
  } exec_res_t;

  // sign-extend (or truncate) the inbox value to the data width
  function automatic data_t inbox_to_data(logic [INBOX_W-1:0] v);
    return DATA_WIDTH'(signed'(v));
  endfunction

endpackage
`default_nettype wire

[sv/ams_req_if.sv]
`default_nettype none
interface ams_req_if;
  logic                          valid;
  logic                          ready;
  logic [ams_pkg::OP_W-1:0]      opcode;
  logic [ams_pkg::ARG_W-1:0]     operand;
  logic signed [ams_pkg::INBOX_W-1:0] inbox_value;

  modport source(output valid, output opcode, output operand, output inbox_value,
                 input ready);
  modport sink(input valid, input opcode, input operand, input inbox_value,
               output ready);
endinterface
`default_nettype wire

[sv/ams_rsp_if.sv]
`default_nettype none
interface ams_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [ams_pkg::PC_W-1:0]              next_pc;
  logic signed [ams_pkg::DATA_WIDTH-1:0] hand_value;
  logic                                  out_valid;
  logic signed [ams_pkg::DATA_WIDTH-1:0] out_value;
  logic                                  halted;
  logic                                  fault;

  modport source(output valid, output next_pc, output hand_value, output out_valid,
                 output out_value, output halted, output fault, input ready);
  modport sink(input valid, input next_pc, input hand_value, input out_valid,
               input out_value, input halted, input fault, output ready);
endinterface
`default_nettype wire

[sv/ams_ground.sv]
`default_nettype none
module ams_ground (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ams_pkg::gidx_t rd_idx,
  output ams_pkg::data_t     rd_data,
  input  wire logic          we,
  input  wire ams_pkg::gidx_t wr_idx,
  input  wire ams_pkg::data_t wr_data
);

  ams_pkg::data_t                   mem [ams_pkg::GROUND_DEPTH];
  logic [ams_pkg::GROUND_DEPTH-1:0] vld;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  assign rd_data = vld[rd_idx] ? mem[rd_idx] : '0;

endmodule
`default_nettype wire

[sv/ams_exec.sv]
`default_nettype none
module ams_exec (
  input  wire logic [ams_pkg::OP_W-1:0]    opcode,
  input  wire logic [ams_pkg::ARG_W-1:0]   operand,
  input  wire logic [ams_pkg::INBOX_W-1:0] inbox_value,
  input  wire ams_pkg::data_t              hand,
  input  wire ams_pkg::pc_t                pc,
  input  wire ams_pkg::pc_t                eff_len,
  input  wire ams_pkg::data_t              gnd_data,
  output ams_pkg::exec_res_t               res
);

  ams_pkg::op_t op;
  logic         running;
  logic         in_range;
  logic         memop;
  ams_pkg::pc_t pc_inc;
  ams_pkg::pc_t target;

  assign op       = ams_pkg::op_t'(opcode);
  assign running  = pc < eff_len;
  assign in_range = {1'b0, operand} < ams_pkg::PC_W'(ams_pkg::GROUND_DEPTH);
  assign memop    = (op == ams_pkg::OP_ADD) || (op == ams_pkg::OP_SUB) ||
                    (op == ams_pkg::OP_COPYTO) || (op == ams_pkg::OP_COPYFROM);
  assign pc_inc   = pc + ams_pkg::PC_W'(1);
  assign target   = {1'b0, operand};

  always_comb begin
    res           = '0;
    res.hand      = hand;
    res.pc        = pc;
    if (running) begin
      if (memop && !in_range) begin
        res.fault = 1'b1;
      end else begin
        unique case (op)
          ams_pkg::OP_INBOX: begin
            res.hand = ams_pkg::inbox_to_data(inbox_value);
            res.pc   = pc_inc;
          end
          ams_pkg::OP_OUTBOX: begin
            res.out_valid = 1'b1;
            res.out_value = hand;
            res.pc        = pc_inc;
          end
          ams_pkg::OP_ADD: begin
            res.hand = hand + gnd_data;
            res.pc   = pc_inc;
          end
          ams_pkg::OP_SUB: begin
            res.hand = hand - gnd_data;
            res.pc   = pc_inc;
          end
          ams_pkg::OP_COPYTO: begin
            res.gnd_we = 1'b1;
            res.pc     = pc_inc;
          end
          ams_pkg::OP_COPYFROM: begin
            res.hand = gnd_data;
            res.pc   = pc_inc;
          end
          ams_pkg::OP_JUMP: begin
            res.pc = target;
          end
          ams_pkg::OP_JUMPZERO: begin
            res.pc = (hand == '0) ? target : pc_inc;
          end
        endcase
      end
    end
    res.halted = res.pc >= eff_len;
  end

endmodule
`default_nettype wire

[sv/accumulator_machine_step.sv]
// A request loads the input register, and its result loads the result register once
// that is free. Throughput: one instruction per cycle unless the output is blocked;
// the registers run back to back, and the machine state is updated as a result loads.
// Reset (synchronous, active high): hand and pc cleared, scratch memory reads as
// zero, program length back to its full depth, both registers empty.
`default_nettype none
module accumulator_machine_step (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [ams_pkg::PC_W-1:0]  cfg_data,
  ams_req_if.sink                        req,
  ams_rsp_if.source                      rsp
);

  // input register
  logic                          in_vld;
  logic [ams_pkg::OP_W-1:0]      in_op;
  logic [ams_pkg::ARG_W-1:0]     in_arg;
  logic [ams_pkg::INBOX_W-1:0]   in_val;

  // machine state
  ams_pkg::data_t hand;
  ams_pkg::pc_t   pc;
  ams_pkg::pc_t   eff_len;

  // result register
  logic           rsp_vld;
  ams_pkg::pc_t   rsp_pc;
  ams_pkg::data_t rsp_hand;
  logic           rsp_out_valid;
  ams_pkg::data_t rsp_out_value;
  logic           rsp_halted;
  logic           rsp_fault;

  logic               fire;
  ams_pkg::data_t     gnd_data;
  ams_pkg::gidx_t     gidx;
  ams_pkg::exec_res_t res;

  assign fire      = in_vld && (!rsp_vld || rsp.ready);
  assign req.ready = !in_vld || fire;
  assign gidx      = in_arg[ams_pkg::GIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op  <= req.opcode;
      in_arg <= req.operand;
      in_val <= req.inbox_value;
    end
  end

  // program length is kept already clamped to the program depth
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= ams_pkg::PC_W'(ams_pkg::PROG_DEPTH);
    end else if (cfg_we) begin
      eff_len <= (cfg_data > ams_pkg::PC_W'(ams_pkg::PROG_DEPTH)) ?
                 ams_pkg::PC_W'(ams_pkg::PROG_DEPTH) : cfg_data;
    end
  end

  ams_ground u_ground (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (gidx),
    .rd_data (gnd_data),
    .we      (fire && res.gnd_we),
    .wr_idx  (gidx),
    .wr_data (hand)
  );

  ams_exec u_exec (
    .opcode      (in_op),
    .operand     (in_arg),
    .inbox_value (in_val),
    .hand        (hand),
    .pc          (pc),
    .eff_len     (eff_len),
    .gnd_data    (gnd_data),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hand <= '0;
      pc   <= '0;
    end else if (fire) begin
      hand <= res.hand;
      pc   <= res.pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (fire) begin
      rsp_vld <= 1'b1;
    end else if (rsp.ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_pc        <= res.pc;
      rsp_hand      <= res.hand;
      rsp_out_valid <= res.out_valid;
      rsp_out_value <= res.out_value;
      rsp_halted    <= res.halted;
      rsp_fault     <= res.fault;
    end
  end

  assign rsp.valid      = rsp_vld;
  assign rsp.next_pc    = rsp_pc;
  assign rsp.hand_value = rsp_hand;
  assign rsp.out_valid  = rsp_out_valid;
  assign rsp.out_value  = rsp_out_value;
  assign rsp.halted     = rsp_halted;
  assign rsp.fault      = rsp_fault;

  // the input side only stalls when both registers are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (in_vld && rsp_vld && !rsp.ready))
    else $error("input stalled without a blocked result");

  // a step taken while halted leaves pc and hand alone
  a_halt_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && (pc >= eff_len)) |=> (pc == $past(pc)) && (hand == $past(hand)))
    else $error("state changed while halted");

  // a fault never comes with an emitted value, and it does not move pc
  a_fault_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp_vld && rsp_fault) |-> (!rsp_out_valid && (rsp_pc == pc)))
    else $error("faulting request changed pc or emitted");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_vld && !rsp_out_valid) |-> (rsp_out_value == '0))
    else $error("out_value nonzero without outbox");

  // the result shown matches the state it left behind
  a_rsp_state: assert property (@(posedge clk) disable iff (rst)
    fire |=> (rsp_pc == pc) && (rsp_hand == hand))
    else $error("result does not match machine state");

endmodule
`default_nettype wire
